/* hw/rtl/caseless_substring_find_wrap_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef CASELESS_SUBSTRING_FIND_WRAP_ASSERT_SVH
`define CASELESS_SUBSTRING_FIND_WRAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CSF_ASSERT(lbl, prop, msg)
`define CSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/csf_pkg.sv */
package csf_pkg;

  localparam int TEXT_DEPTH = 4096;
  localparam int QUERY_MAX  = 32;
  localparam int AW  = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int CW  = $clog2(TEXT_DEPTH + 1);
  localparam int QIW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

  localparam int OFS_W  = 12;
  localparam int QLEN_W = 6;
  localparam int CFG_W  = 64;
  localparam int CIDX_W = 3;

  localparam logic [CIDX_W-1:0] CFG_QCHARS_LOW      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_QCHARS_MID_LOW  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_QCHARS_MID_HIGH = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_QCHARS_HIGH     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_QLEN            = 3'd4;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;
  localparam logic DIR_FWD    = 1'b0;
  localparam logic DIR_BACK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } csf_state_e;

  typedef struct packed {
    logic       shift;
    logic       care;
    logic [7:0] qchar;
  } csf_cell_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/csf_in_if.sv */
interface csf_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [7:0]               text_byte;
  logic                     restart_text;
  logic [csf_pkg::OFS_W-1:0] start_ofs;
  logic                     skip_start;
  logic                     direction;

  modport source (output valid, action, text_byte, restart_text, start_ofs,
                  skip_start, direction, input ready);
  modport sink (input valid, action, text_byte, restart_text, start_ofs,
                skip_start, direction, output ready);
endinterface

/* hw/rtl/csf_out_if.sv */
interface csf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [csf_pkg::OFS_W-1:0]  match_offset;
  logic [csf_pkg::QLEN_W-1:0] match_length;
  logic                      wrapped;

  modport source (output valid, found, match_offset, match_length, wrapped,
                  input ready);
  modport sink (input valid, found, match_offset, match_length, wrapped,
                output ready);
endinterface

/* hw/rtl/csf_cell.sv */
module csf_cell (
  input  logic                   clk_i,
  input  csf_pkg::csf_cell_ctl_t ctl_i,
  input  logic [7:0]             byte_i,
  output logic [7:0]             byte_o,
  output logic                   hit_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // cells past the query length always agree
  assign hit_o  = !ctl_i.care || (csf_pkg::fold(byte_q) == csf_pkg::fold(ctl_i.qchar));

endmodule

/* hw/rtl/csf_text_mem.sv */
module csf_text_mem (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [csf_pkg::AW-1:0] waddr_i,
  input  logic [7:0]             wdata_i,
  input  logic [csf_pkg::AW-1:0] raddr_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [csf_pkg::TEXT_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/caseless_substring_find_wrap.sv */
// Load items are accepted back to back while no search runs.
// Search item: the text streams one byte per cycle from the store's single
// read port through the cell row.
// Result sits in an output register; loads are taken while it waits.
// Reset clears the text count, query registers and control; store contents
// are left as they are and read only below the count.
`include "caseless_substring_find_wrap_assert.svh"

module caseless_substring_find_wrap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  csf_in_if.sink                     in_ch,
  csf_out_if.source                  out_ch,
  input  logic                       cfg_we_i,
  input  logic [csf_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [csf_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int CW = csf_pkg::CW;
  localparam int QM = csf_pkg::QUERY_MAX;

  // configuration
  logic [4*csf_pkg::CFG_W-1:0] qvec_q;
  logic [csf_pkg::QLEN_W-1:0]  qlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qvec_q <= '0;
      qlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csf_pkg::CFG_QCHARS_LOW:      qvec_q[0*64 +: 64] <= cfg_data_i;
        csf_pkg::CFG_QCHARS_MID_LOW:  qvec_q[1*64 +: 64] <= cfg_data_i;
        csf_pkg::CFG_QCHARS_MID_HIGH: qvec_q[2*64 +: 64] <= cfg_data_i;
        csf_pkg::CFG_QCHARS_HIGH:     qvec_q[3*64 +: 64] <= cfg_data_i;
        csf_pkg::CFG_QLEN:            qlen_q <= cfg_data_i[csf_pkg::QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  csf_pkg::csf_state_e state_q, state_d;
  logic in_rdy, issue, load_out;
  logic in_acc, load_acc, search_acc;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_q;
  logic          rd_vld_q, vld2_q;
  logic [CW-1:0] pos1_q, pos2_q;

  assign in_acc     = in_ch.valid && in_rdy;
  assign load_acc   = in_acc && (in_ch.action == csf_pkg::ACT_LOAD);
  assign search_acc = in_acc && (in_ch.action != csf_pkg::ACT_LOAD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csf_pkg::ST_IDLE:   if (search_acc) state_d = csf_pkg::ST_SCAN;
      csf_pkg::ST_SCAN:   if (rd_q >= cnt_q) state_d = csf_pkg::ST_DRAIN;
      csf_pkg::ST_DRAIN:  if (!rd_vld_q && !vld2_q) state_d = csf_pkg::ST_FINISH;
      csf_pkg::ST_FINISH: if (!out_ch.valid || out_ch.ready) state_d = csf_pkg::ST_IDLE;
      default:            state_d = csf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy   = (state_q == csf_pkg::ST_IDLE);
    issue    = (state_q == csf_pkg::ST_SCAN) && (rd_q < cnt_q);
    load_out = (state_q == csf_pkg::ST_FINISH) && (!out_ch.valid || out_ch.ready);
  end

  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // text store and count
  logic                   mem_we;
  logic [csf_pkg::AW-1:0] mem_waddr;
  logic [7:0]             mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[csf_pkg::AW-1:0];
    cnt_d     = cnt_q;
    if (load_acc) begin
      if (in_ch.restart_text) begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        cnt_d     = CW'(1);
      end else if (cnt_q < CW'(csf_pkg::TEXT_DEPTH)) begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  csf_text_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_ch.text_byte),
    .raddr_i (rd_q[csf_pkg::AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // read address sweep and position pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= '0;
      rd_vld_q <= 1'b0;
      vld2_q   <= 1'b0;
    end else begin
      if (search_acc) begin
        rd_q <= '0;
      end else if (issue) begin
        rd_q <= rd_q + CW'(1);
      end
      rd_vld_q <= issue;
      vld2_q   <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos1_q <= rd_q;
    pos2_q <= pos1_q;
  end

  // cell row: cell k holds the byte k positions behind the newest one
  logic [7:0]    cell_byte [QM];
  logic [QM-1:0] cell_hit;

  for (genvar k = 0; k < QM; k++) begin : g_cell
    csf_pkg::csf_cell_ctl_t ctl;
    logic [csf_pkg::QLEN_W-1:0] qi;
    logic [7:0] in_byte;

    assign qi = qlen_q - csf_pkg::QLEN_W'(1) - csf_pkg::QLEN_W'(k);
    assign ctl.shift = rd_vld_q;
    assign ctl.care  = (csf_pkg::QLEN_W'(k) < qlen_q);
    assign ctl.qchar = qvec_q[qi[csf_pkg::QIW-1:0]*8 +: 8];

    if (k == 0) begin : g_head
      assign in_byte = mem_rdata;
    end else begin : g_link
      assign in_byte = cell_byte[k-1];
    end

    csf_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .byte_i (in_byte),
      .byte_o (cell_byte[k]),
      .hit_o  (cell_hit[k])
    );
  end

  // match tracking
  logic          qlen_ok, hit;
  logic [CW:0]   pos_plus;
  logic [CW-1:0] hit_pos;
  logic [CW-1:0] first_q, start_q;
  logic          nofirst_q, back_q;
  logic          f1_q, fa_q, b1_q, ba_q;
  logic [CW-1:0] f1p_q, fap_q, b1p_q, bap_q;

  assign qlen_ok  = (qlen_q != '0) && (qlen_q <= csf_pkg::QLEN_W'(QM));
  assign pos_plus = {1'b0, pos2_q} + (CW + 1)'(1);
  assign hit      = vld2_q && qlen_ok && (&cell_hit) && (pos_plus >= (CW + 1)'(qlen_q));
  assign hit_pos  = CW'(pos_plus - (CW + 1)'(qlen_q));

  always_ff @(posedge clk_i) begin
    if (search_acc) begin
      first_q   <= CW'(in_ch.start_ofs) + CW'(in_ch.skip_start);
      start_q   <= CW'(in_ch.start_ofs) - CW'(in_ch.skip_start);
      nofirst_q <= in_ch.skip_start && (in_ch.start_ofs == '0);
      back_q    <= (in_ch.direction == csf_pkg::DIR_BACK);
    end
    if (hit) begin
      if (!f1_q && hit_pos >= first_q) f1p_q <= hit_pos;
      if (!fa_q) fap_q <= hit_pos;
      if (!nofirst_q && hit_pos <= start_q) b1p_q <= hit_pos;
      bap_q <= hit_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= 1'b0;
      fa_q <= 1'b0;
      b1_q <= 1'b0;
      ba_q <= 1'b0;
    end else if (search_acc) begin
      f1_q <= 1'b0;
      fa_q <= 1'b0;
      b1_q <= 1'b0;
      ba_q <= 1'b0;
    end else if (hit) begin
      if (hit_pos >= first_q) f1_q <= 1'b1;
      fa_q <= 1'b1;
      if (!nofirst_q && hit_pos <= start_q) b1_q <= 1'b1;
      ba_q <= 1'b1;
    end
  end

  // result register
  logic                       out_vld_q;
  logic                       found_q, wrapped_q;
  logic [csf_pkg::OFS_W-1:0]  ofs_q;
  logic [csf_pkg::QLEN_W-1:0] mlen_q;
  logic                       found_d, wrapped_d;
  logic [CW-1:0]              ofs_d;

  always_comb begin
    found_d   = 1'b0;
    wrapped_d = 1'b0;
    ofs_d     = '0;
    if (!back_q) begin
      priority if (f1_q) begin
        found_d = 1'b1;
        ofs_d   = f1p_q;
      end else if (fa_q) begin
        found_d   = 1'b1;
        wrapped_d = 1'b1;
        ofs_d     = fap_q;
      end
    end else begin
      priority if (b1_q) begin
        found_d = 1'b1;
        ofs_d   = b1p_q;
      end else if (ba_q) begin
        found_d   = 1'b1;
        wrapped_d = 1'b1;
        ofs_d     = bap_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_q   <= found_d;
      wrapped_q <= wrapped_d;
      ofs_q     <= csf_pkg::OFS_W'(ofs_d);
      mlen_q    <= found_d ? qlen_q : '0;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.found        = found_q;
  assign out_ch.match_offset = ofs_q;
  assign out_ch.match_length = mlen_q;
  assign out_ch.wrapped      = wrapped_q;

  `CSF_ASSERT(a_read_in_text, rd_vld_q |-> (pos1_q < cnt_q), "read beyond text count")
  `CSF_ASSERT(a_first_implies_any, f1_q |-> fa_q, "forward hit without any hit")
  `CSF_ASSERT(a_back_implies_any, b1_q |-> ba_q, "backward hit without any hit")
  `CSF_ASSERT(a_count_bound, cnt_q <= CW'(csf_pkg::TEXT_DEPTH), "text count past depth")
  `CSF_ASSERT(a_no_load_in_scan, (state_q != csf_pkg::ST_IDLE) |=> $stable(cnt_q) || (state_q == csf_pkg::ST_IDLE), "count moved during search")

endmodule

/* tb/csf_search_checker.sv */
module csf_search_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  csf_in_if                          in_ch,
  csf_out_if                         out_ch,
  input  logic                       cfg_we_i,
  input  logic [csf_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [csf_pkg::CFG_W-1:0]  cfg_data_i,
  output int                         fail_count,
  output int                         pending_results
);
  import csf_pkg::*;

  typedef struct packed {
    logic               found;
    logic [OFS_W-1:0]   match_offset;
    logic [QLEN_W-1:0]  match_length;
    logic               wrapped;
  } search_result_t;

  logic [CFG_W-1:0]  query_word [4];
  logic [QLEN_W-1:0] qry_len;
  logic [7:0]        text_mem [TEXT_DEPTH];
  int                txt_cnt;
  search_result_t    expected_results [$];

  assign pending_results = expected_results.size();

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic bit query_at(input int pos);
    logic [7:0] qc;
    for (int i = 0; i < int'(qry_len); i++) begin
      qc = query_word[i / 8][(i % 8) * 8 +: 8];
      if (to_lower(text_mem[pos + i]) != to_lower(qc)) return 0;
    end
    return 1;
  endfunction

  function automatic int find_up(input int first, input int last);
    for (int p = first; p <= last; p++) if (query_at(p)) return p;
    return -1;
  endfunction

  function automatic int find_down(input int start);
    for (int p = start; p >= 0; p--) if (query_at(p)) return p;
    return -1;
  endfunction

  function automatic search_result_t predict_search(input logic [OFS_W-1:0] anchor,
                                                    input logic skip, input logic dir);
    search_result_t r;
    int last, first, start, hit;
    logic wrap;
    r = '0;
    hit = -1;
    wrap = 0;
    if (qry_len != 0 && qry_len <= QUERY_MAX && int'(qry_len) <= txt_cnt) begin
      last = txt_cnt - int'(qry_len);
      if (dir != DIR_BACK) begin
        first = skip ? int'(anchor) + 1 : int'(anchor);
        if (first <= last) hit = find_up(first, last);
        if (hit < 0) begin
          hit = find_up(0, last);
          wrap = 1;
        end
      end else if (skip && anchor == 0) begin
        hit = find_down(last);
        wrap = 1;
      end else begin
        start = skip ? int'(anchor) - 1 : int'(anchor);
        if (start > last) start = last;
        hit = find_down(start);
        if (hit < 0) begin
          hit = find_down(last);
          wrap = 1;
        end
      end
    end
    if (hit >= 0) begin
      r.found        = 1'b1;
      r.match_offset = hit[OFS_W-1:0];
      r.match_length = qry_len;
      r.wrapped      = wrap;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) query_word[i] = '0;
      qry_len = '0;
      txt_cnt = 0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.found, out_ch.match_offset, out_ch.match_length, out_ch.wrapped};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no search outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b want %0b", got.found, want.found));
          if (got.match_offset !== want.match_offset)
            report_mismatch($sformatf("match_offset %0d want %0d",
                                      got.match_offset, want.match_offset));
          if (got.match_length !== want.match_length)
            report_mismatch($sformatf("match_length %0d want %0d",
                                      got.match_length, want.match_length));
          if (got.wrapped !== want.wrapped)
            report_mismatch($sformatf("wrapped %0b want %0b", got.wrapped, want.wrapped));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          if (in_ch.restart_text) txt_cnt = 0;
          if (txt_cnt < TEXT_DEPTH) begin
            text_mem[txt_cnt] = in_ch.text_byte;
            txt_cnt++;
          end
        end else begin
          expected_results.push_back(predict_search(in_ch.start_ofs,
                                                    in_ch.skip_start, in_ch.direction));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QCHARS_LOW, CFG_QCHARS_MID_LOW, CFG_QCHARS_MID_HIGH, CFG_QCHARS_HIGH: begin
            query_word[cfg_idx_i] = cfg_data_i;
          end
          CFG_QLEN: qry_len = cfg_data_i[QLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/tb_caseless_substring_find_wrap.sv */
module tb_caseless_substring_find_wrap;
  import csf_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  int                fail_count;
  int                pending_results;
  int                cycles;
  int                items_sent;
  int                loaded_cnt;
  bit                calm;
  logic [7:0]        query_bytes [32];

  csf_in_if  in_ch ();
  csf_out_if out_ch ();

  caseless_substring_find_wrap dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  csf_search_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL caseless_substring_find_wrap");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  task automatic send(input logic act, input logic [7:0] b, input logic restart,
                      input logic [OFS_W-1:0] anchor, input logic skip, input logic dir);
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.text_byte     <= b;
    in_ch.restart_text  <= restart;
    in_ch.start_ofs     <= anchor;
    in_ch.skip_start    <= skip;
    in_ch.direction     <= dir;
    #1;
    while (!in_ch.ready) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    items_sent++;
    if (act == ACT_LOAD) begin
      if (restart) loaded_cnt = 0;
      if (loaded_cnt < TEXT_DEPTH) loaded_cnt++;
    end
  endtask

  task automatic load_byte(input logic [7:0] b, input logic restart);
    send(ACT_LOAD, b, restart, OFS_W'($urandom), $urandom_range(1), $urandom_range(1));
  endtask

  task automatic search(input logic [OFS_W-1:0] anchor, input logic skip, input logic dir);
    send(ACT_SEARCH, 8'($urandom), $urandom_range(1), anchor, skip, dir);
  endtask

  // Hold until every search has answered, then idle before returning.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    repeat (loaded_cnt + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_query(input int qlen);
    logic [CFG_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 8; j++) w[j*8 +: 8] = query_bytes[k*8 + j];
      write_reg(CIDX_W'(k), w);
    end
    write_reg(CFG_QLEN, CFG_W'(qlen));
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return 8'($urandom);
      1, 2: return "a";
      3, 4: return "A";
      5, 6: return "b";
      7: return "B";
      default: return "1";
    endcase
  endfunction

  initial begin
    string       txt;
    int          qlen, tlen, nsearch, pos;
    logic [7:0]  c;
    cycles      = 0;
    items_sent  = 0;
    loaded_cnt  = 0;
    calm        = 0;
    rst_ni      = 0;
    cfg_we_i    = 0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_ch.valid = 0;
    in_ch.action = ACT_LOAD;
    in_ch.text_byte = '0;
    in_ch.restart_text = 0;
    in_ch.start_ofs = '0;
    in_ch.skip_start = 0;
    in_ch.direction = DIR_FWD;
    out_ch.ready = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: search before any text with the reset query
    search('0, 0, DIR_FWD);
    for (int i = 0; i < 32; i++) query_bytes[i] = 8'hFF;
    query_bytes[0] = "a";
    query_bytes[1] = "B";
    query_bytes[2] = "1";
    drain();
    set_query(3);
    txt = "xAb1zab1";
    for (int i = 0; i < txt.len(); i++) load_byte(txt[i], i == 0);
    load_byte(8'hFF, 0);
    load_byte(8'h00, 0);
    search(12'd0, 0, DIR_FWD);
    search(12'd1, 1, DIR_FWD);
    search(12'd4095, 0, DIR_FWD);
    search(12'd4095, 0, DIR_BACK);
    search(12'd0, 1, DIR_BACK);
    search(12'd4, 1, DIR_BACK);
    search(12'd1, 0, DIR_BACK);
    drain();
    set_query(0);
    search(12'd0, 0, DIR_FWD);
    drain();
    set_query(33);
    search(12'd0, 0, DIR_FWD);
    drain();
    set_query(32);
    search(12'd5, 0, DIR_BACK);
    drain();

    // random phases; a few early ones run with no idling
    for (int ph = 0; items_sent < 2000 || ph < 7; ph++) begin
      calm = (ph >= 1 && ph < 7);
      case ($urandom_range(9))
        0: qlen = 0;
        1: qlen = $urandom_range(1) ? 32 : $urandom_range(63, 33);
        default: qlen = $urandom_range(4, 1);
      endcase
      for (int i = 0; i < 32; i++) query_bytes[i] = (qlen >= 32) ? 8'($urandom) : pick_char();
      if (ph == 5) qlen = 63;
      set_query(qlen);
      if ($urandom_range(49) == 0) tlen = $urandom_range(1000, 300);
      else tlen = $urandom_range(40, 1);
      pos = $urandom_range(tlen);
      for (int i = 0; i < tlen; i++) begin
        c = pick_char();
        if (qlen > 0 && qlen <= 32 && i >= pos && i < pos + qlen) c = query_bytes[i - pos];
        if ($urandom_range(1)) c = flip_case(c);
        load_byte(c, i == 0);
      end
      nsearch = $urandom_range(8, 1);
      for (int s = 0; s < nsearch; s++) begin
        if ($urandom_range(4) == 0) load_byte(pick_char(), 0);
        case ($urandom_range(5))
          0: search(OFS_W'($urandom), $urandom_range(1), $urandom_range(1));
          1: search('0, $urandom_range(1), $urandom_range(1));
          default: search(OFS_W'($urandom_range(loaded_cnt)), $urandom_range(1),
                          $urandom_range(1));
        endcase
      end
      drain();
    end

    calm = 1;
    drain();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS caseless_substring_find_wrap");
    end else begin
      $display("FAIL caseless_substring_find_wrap");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/csf_pkg.sv
hw/rtl/csf_in_if.sv
hw/rtl/csf_out_if.sv
hw/rtl/csf_cell.sv
hw/rtl/csf_text_mem.sv
hw/rtl/caseless_substring_find_wrap.sv
tb/csf_search_checker.sv
tb/tb_caseless_substring_find_wrap.sv
